// ===== src/bpdc_pkg.sv =====
`timescale 1ns / 1ps

package bpdc_pkg;

  // ADC conversion width and full-scale code.
  localparam int ADC_W = 12;
  localparam int ADC_FS = (1 << ADC_W) - 1;
  localparam int IN_TDATA_W = ((ADC_W + 7) / 8) * 8;

  // Volts in Q6.8: feedback = adc * 33 * 256 / full scale; 8448 = 2^13 + 2^8.
  localparam int FB_W = 14;
  localparam int FBX_W = ADC_W + 14;

  // Register file.
  localparam int CFG_W = 24;
  localparam int CFG_AW = 3;
  localparam int VOLT_W = 14;
  localparam int GAIN_W = 24;
  localparam int DUTY_W = 16;

  localparam logic [CFG_AW-1:0] REG_TARGET = 3'd0;
  localparam logic [CFG_AW-1:0] REG_PGAIN = 3'd1;
  localparam logic [CFG_AW-1:0] REG_IGAIN = 3'd2;
  localparam logic [CFG_AW-1:0] REG_DUTY_HI = 3'd3;
  localparam logic [CFG_AW-1:0] REG_DUTY_LO = 3'd4;
  localparam logic [CFG_AW-1:0] REG_ILIMIT = 3'd5;
  localparam logic [CFG_AW-1:0] REG_MIN_FB = 3'd6;

  // Output word: duty in the low half, feedback volts above it.
  localparam int OUT_TDATA_W = ((DUTY_W + FB_W + 7) / 8) * 8;

  // Shared multiplier.
  localparam int MA_W = 25;
  localparam int MB_W = 20;
  localparam int PROD_W = MA_W + MB_W;

  // Feedforward target*16/3 by reciprocal: ceil(2^20 / 3), exact for inputs below 2^19.
  localparam int FF_SH = 20;
  localparam int FF_M = ((1 << FF_SH) + 2) / 3;
  localparam int FF_W = 17;

  localparam int ERR_W = 16;
  localparam int TERM_W = 25;
  localparam int INTEG_W = 18;
  localparam int ISUM_W = 26;
  localparam int DSUM_W = 27;

  // Microcode.
  localparam int PC_W = 3;

  typedef enum logic [1:0] {
    MUL_NONE,
    MUL_FF,
    MUL_P,
    MUL_I
  } mul_sel_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_FB_EST,
    OP_FB_FIX,
    OP_ERR,
    OP_FF_TAKE,
    OP_P_TAKE,
    OP_INTEG,
    OP_DUTY
  } alu_op_t;

  typedef enum logic {
    JMP_NONE,
    JMP_LOW
  } jmp_t;

  typedef struct packed {
    mul_sel_t mul;
    alu_op_t op;
    jmp_t jmp;
    logic last;
  } ucw_t;

  function automatic ucw_t ucode(input logic [PC_W-1:0] pc);
    ucw_t cw;
    case (pc)
      3'd0: cw = '{mul: MUL_NONE, op: OP_FB_EST, jmp: JMP_NONE, last: 1'b0};
      3'd1: cw = '{mul: MUL_NONE, op: OP_FB_FIX, jmp: JMP_NONE, last: 1'b0};
      3'd2: cw = '{mul: MUL_FF, op: OP_ERR, jmp: JMP_LOW, last: 1'b0};
      3'd3: cw = '{mul: MUL_P, op: OP_FF_TAKE, jmp: JMP_NONE, last: 1'b0};
      3'd4: cw = '{mul: MUL_I, op: OP_P_TAKE, jmp: JMP_NONE, last: 1'b0};
      3'd5: cw = '{mul: MUL_NONE, op: OP_INTEG, jmp: JMP_NONE, last: 1'b0};
      3'd6: cw = '{mul: MUL_NONE, op: OP_DUTY, jmp: JMP_NONE, last: 1'b1};
      default: cw = '{mul: MUL_NONE, op: OP_NOP, jmp: JMP_NONE, last: 1'b1};
    endcase
    return cw;
  endfunction

endpackage

// ===== src/buck_pi_duty_controller.sv =====
`timescale 1ns / 1ps

// Buck converter voltage-loop duty controller: PI with feedforward and anti-windup.
// The input stream carries one raw output-voltage ADC word per sample on in_tdata.
// The result stream carries the clamped duty command and the scaled feedback volts.
// Samples whose feedback falls below the min_feedback register produce no word and
// leave the integrator untouched. The user writes gains and limits via the cfg_ port,
// one register per write, only while the block is idle; the block does not enforce it.
// An accepted sample runs through a seven-step microprogram held in a small ROM; a
// step counter drives one shared multiplier and one adder path. A result word shows
// on out_tvalid once the final step has run, and in_tready returns in that same
// cycle, so the block takes a new sample only once it is through with the last. The
// three multiplications share the one multiplier, so each takes a step of its own. A
// sample below the threshold ends after three steps, so the next can follow sooner.
// The result sits in an output register; while the receiver stalls, the next sample
// is still accepted and worked on, and only its final step waits until the
// register is free.
// Synchronous reset (rst_n low) clears the integrator, loads the register defaults,
// drops out_tvalid and returns the sequencer to idle.
module buck_pi_duty_controller
  import bpdc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // adc_sample
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // duty_cycle, feedback_volts
  input  logic                   cfg_wr_en,
  input  logic [CFG_AW-1:0]      cfg_addr,
  input  logic [CFG_W-1:0]       cfg_wdata
);

  // Configuration registers.
  logic [VOLT_W-1:0] target_r;
  logic [GAIN_W-1:0] pgain_r;
  logic [GAIN_W-1:0] igain_r;
  logic [DUTY_W-1:0] duty_hi_r;
  logic [DUTY_W-1:0] duty_lo_r;
  logic [DUTY_W-1:0] ilimit_r;
  logic [VOLT_W-1:0] min_fb_r;

  // Sequencer.
  logic            busy_r, busy_nxt;
  logic [PC_W-1:0] pc_r, pc_nxt;
  ucw_t            cw;
  logic            advance;
  logic            low_fb;

  // Datapath registers.
  logic [ADC_W-1:0]         adc_r;
  logic [FB_W-1:0]          fb_r, fb_nxt;
  logic signed [ERR_W-1:0]  err_r, err_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic [FF_W-1:0]          ff_r, ff_nxt;
  logic signed [TERM_W-1:0] p_r, p_nxt;
  logic signed [INTEG_W-1:0] integ_r, integ_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic [DUTY_W-1:0]        out_duty_r, out_duty_nxt;
  logic [FB_W-1:0]          out_fb_r, out_fb_nxt;

  // Combinational helpers.
  logic [FBX_W-1:0]          x_scaled;
  logic [FBX_W:0]            est_sum;
  logic [FBX_W:0]            fb_rem;
  logic signed [MA_W-1:0]    mul_a;
  logic signed [MB_W-1:0]    mul_b;
  logic signed [PROD_W-1:0]  prod_adj;
  logic signed [TERM_W-1:0]  term;
  logic signed [INTEG_W-1:0] lim_pos, lim_neg;
  logic                      integ_gate;
  logic signed [ISUM_W-1:0]  isum;
  logic signed [DSUM_W-1:0]  dsum;
  logic signed [DSUM_W-1:0]  dhi, dlo;

  assign cw = ucode(pc_r);
  assign in_tready = !busy_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata = {{(OUT_TDATA_W - DUTY_W - FB_W){1'b0}}, out_fb_r, out_duty_r};

  // The final step waits while the previous result is still unread.
  assign advance = busy_r && !(cw.op == OP_DUTY && out_valid_r && !out_tready);
  assign low_fb = fb_r < min_fb_r;

  // Feedback scaling: x = adc * 8448, then x / full scale by the series
  // x/2^W + x/2^(2W), which undershoots by at most one; a remainder test fixes it.
  assign x_scaled = (FBX_W'(adc_r) << 13) + (FBX_W'(adc_r) << 8);
  assign est_sum  = (FBX_W + 1)'(x_scaled) + (FBX_W + 1)'(x_scaled >> ADC_W);
  assign fb_rem   = (FBX_W + 1)'(x_scaled) - ((FBX_W + 1)'(fb_r) << ADC_W)
                    + (FBX_W + 1)'(fb_r);

  // Product shifted right by 16, rounded toward zero.
  assign prod_adj = prod_r[PROD_W-1] ? prod_r + $signed(PROD_W'(17'h0FFFF)) : prod_r;
  assign term = $signed(prod_adj[16 +: TERM_W]);

  assign lim_pos = $signed(INTEG_W'(ilimit_r));
  assign lim_neg = -lim_pos;
  assign integ_gate = (integ_r <= lim_pos) && (integ_r >= lim_neg);
  assign isum = ISUM_W'(integ_r) + (integ_gate ? ISUM_W'(term) : '0);

  assign dsum = $signed(DSUM_W'(ff_r)) + DSUM_W'(p_r) + DSUM_W'(integ_r);
  assign dhi = $signed(DSUM_W'(duty_hi_r));
  assign dlo = $signed(DSUM_W'(duty_lo_r));

  always_comb begin
    case (cw.mul)
      MUL_FF: begin
        mul_a = $signed(MA_W'({target_r, 4'b0000}));
        mul_b = $signed(MB_W'(FF_M));
      end
      MUL_P: begin
        mul_a = $signed(MA_W'(pgain_r));
        mul_b = MB_W'(err_r);
      end
      MUL_I: begin
        mul_a = $signed(MA_W'(igain_r));
        mul_b = MB_W'(err_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    busy_nxt = busy_r;
    pc_nxt = pc_r;
    fb_nxt = fb_r;
    err_nxt = err_r;
    prod_nxt = prod_r;
    ff_nxt = ff_r;
    p_nxt = p_r;
    integ_nxt = integ_r;
    out_valid_nxt = out_valid_r;
    out_duty_nxt = out_duty_r;
    out_fb_nxt = out_fb_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    if (in_tvalid && in_tready) begin
      busy_nxt = 1'b1;
      pc_nxt = '0;
    end else if (advance) begin
      if (cw.mul != MUL_NONE) begin
        prod_nxt = mul_a * mul_b;
      end
      case (cw.op)
        OP_FB_EST: fb_nxt = FB_W'(est_sum >> ADC_W);
        OP_FB_FIX: begin
          if (fb_rem >= (FBX_W + 1)'(ADC_FS)) begin
            fb_nxt = fb_r + 1'b1;
          end
        end
        OP_ERR: err_nxt = $signed(ERR_W'(target_r)) - $signed(ERR_W'(fb_r));
        OP_FF_TAKE: ff_nxt = prod_r[FF_SH +: FF_W];
        OP_P_TAKE: p_nxt = term;
        OP_INTEG: begin
          if (isum > ISUM_W'(lim_pos)) begin
            integ_nxt = lim_pos;
          end else if (isum < ISUM_W'(lim_neg)) begin
            integ_nxt = lim_neg;
          end else begin
            integ_nxt = INTEG_W'(isum);
          end
        end
        OP_DUTY: begin
          out_valid_nxt = 1'b1;
          out_fb_nxt = fb_r;
          if (dsum > dhi) begin
            out_duty_nxt = duty_hi_r;
          end else if (dsum < dlo) begin
            out_duty_nxt = duty_lo_r;
          end else begin
            out_duty_nxt = DUTY_W'(dsum);
          end
        end
        default: ;
      endcase
      if (cw.last || (cw.jmp == JMP_LOW && low_fb)) begin
        busy_nxt = 1'b0;
      end else begin
        pc_nxt = pc_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pc_r <= '0;
      out_valid_r <= 1'b0;
      integ_r <= '0;
      target_r <= VOLT_W'(6144);
      pgain_r <= GAIN_W'(83886);
      igain_r <= GAIN_W'(8389);
      duty_hi_r <= DUTY_W'(52429);
      duty_lo_r <= DUTY_W'(13107);
      ilimit_r <= DUTY_W'(9830);
      min_fb_r <= VOLT_W'(2560);
    end else begin
      busy_r <= busy_nxt;
      pc_r <= pc_nxt;
      out_valid_r <= out_valid_nxt;
      integ_r <= integ_nxt;
      if (cfg_wr_en) begin
        case (cfg_addr)
          REG_TARGET: target_r <= cfg_wdata[VOLT_W-1:0];
          REG_PGAIN: pgain_r <= cfg_wdata[GAIN_W-1:0];
          REG_IGAIN: igain_r <= cfg_wdata[GAIN_W-1:0];
          REG_DUTY_HI: duty_hi_r <= cfg_wdata[DUTY_W-1:0];
          REG_DUTY_LO: duty_lo_r <= cfg_wdata[DUTY_W-1:0];
          REG_ILIMIT: ilimit_r <= cfg_wdata[DUTY_W-1:0];
          REG_MIN_FB: min_fb_r <= cfg_wdata[VOLT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      adc_r <= in_tdata[ADC_W-1:0];
    end
    fb_r <= fb_nxt;
    err_r <= err_nxt;
    prod_r <= prod_nxt;
    ff_r <= ff_nxt;
    p_r <= p_nxt;
    out_duty_r <= out_duty_nxt;
    out_fb_r <= out_fb_nxt;
  end

endmodule

// ===== src/bpdc_checker.sv =====
`timescale 1ns / 1ps

module bpdc_checker
  import bpdc_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   cfg_wr_en
);

  // A pending result word is held until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word dropped or changed while stalled");

  // One sample at a time: after an input word is taken, the input side closes.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second sample accepted while one is in flight");

  // Reset leaves no result pending.
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // Feedback volts never exceed full-scale 33 V, and the pad bits stay zero.
  a_fb_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[DUTY_W +: FB_W] <= FB_W'(8448))
      && (out_tdata[OUT_TDATA_W-1:DUTY_W+FB_W] == '0))
    else $error("feedback field out of range");

  // Registers are only written while no sample is being worked on.
  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr_en |-> in_tready)
    else $error("register written while a sample is in flight");

endmodule

bind buck_pi_duty_controller bpdc_checker u_bpdc_checker (.*);
